>>> design/spa_pkg.sv
// Shared types and constants for the sparse polynomial adder.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package spa_pkg;

   // Field widths of one stored term: coefficient above exponent.
   localparam int COEF_W  = 16;
   localparam int EXP_W   = 10;
   localparam int ENTRY_W = COEF_W + EXP_W;
   localparam int SUM_W   = COEF_W + 1;

   // Default number of terms each store can hold.
   localparam int TERM_DEPTH_DEF = 32;

   // Stream word widths.
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [1:0] {
      CMD_LOAD_FIRST  = 2'd0,
      CMD_LOAD_SECOND = 2'd1,
      CMD_MERGE       = 2'd2,
      CMD_UNUSED      = 2'd3
   } cmd_type;

   // Outcome of one step of the merge.
   typedef struct packed {
      logic                    take_a;
      logic                    take_b;
      logic                    has_term;
      logic signed [SUM_W-1:0] coef;
      logic [EXP_W-1:0]        expo;
   } pick_type;

endpackage

>>> design/spa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`timescale 1ns / 1ps

module spa_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/spa_term_alu.sv
// Shared compare and add unit: picks the next result term from two list heads.
// Depends on spa_pkg.
`timescale 1ns / 1ps

module spa_term_alu (
   input  logic [spa_pkg::ENTRY_W-1:0] a_entry,
   input  logic [spa_pkg::ENTRY_W-1:0] b_entry,
   input  logic                        a_live,
   input  logic                        b_live,
   output spa_pkg::pick_type           pick
);
   import spa_pkg::*;

   logic signed [COEF_W-1:0] a_coef;
   logic signed [COEF_W-1:0] b_coef;
   logic [EXP_W-1:0]         a_exp;
   logic [EXP_W-1:0]         b_exp;
   logic signed [SUM_W-1:0]  sum;

   assign a_coef = a_entry[ENTRY_W-1:EXP_W];
   assign b_coef = b_entry[ENTRY_W-1:EXP_W];
   assign a_exp  = a_entry[EXP_W-1:0];
   assign b_exp  = b_entry[EXP_W-1:0];
   assign sum    = SUM_W'(a_coef) + SUM_W'(b_coef);

   always_comb begin
      pick = '0;
      if (a_live && b_live) begin
         if (a_exp == b_exp) begin
            // Equal exponents combine; a sum that cancels leaves no term.
            pick.take_a   = 1'b1;
            pick.take_b   = 1'b1;
            pick.has_term = (sum != '0);
            pick.coef     = sum;
            pick.expo     = a_exp;
         end else if (a_exp > b_exp) begin
            pick.take_a   = 1'b1;
            pick.has_term = 1'b1;
            pick.coef     = SUM_W'(a_coef);
            pick.expo     = a_exp;
         end else begin
            pick.take_b   = 1'b1;
            pick.has_term = 1'b1;
            pick.coef     = SUM_W'(b_coef);
            pick.expo     = b_exp;
         end
      end else if (a_live) begin
         pick.take_a   = 1'b1;
         pick.has_term = 1'b1;
         pick.coef     = SUM_W'(a_coef);
         pick.expo     = a_exp;
      end else if (b_live) begin
         pick.take_b   = 1'b1;
         pick.has_term = 1'b1;
         pick.coef     = SUM_W'(b_coef);
         pick.expo     = b_exp;
      end
   end

endmodule

>>> design/sparse_polynomial_add_top.sv
// Top level of the sparse polynomial adder: term stores, merge sequencer, result register.
// Depends on spa_pkg, spa_ram and spa_term_alu.
`timescale 1ns / 1ps

// The block holds two polynomials, each a list of (coefficient, exponent) terms
// that the user loads one transaction at a time, highest exponent first. A
// merge transaction walks both lists with a single shared compare/add unit:
// every step reads the two list heads from the term RAMs (registered read)
// and evaluates them in the next cycle. A merge takes at most first_count +
// second_count steps, and a step waits while the result side stalls. One
// result term is held back until the next one is known, so that the final
// term can carry tlast; a sum that cancels to nothing gives the single term
// 0 x^0. Loads past TERM_DEPTH are dropped and reported in tuser on every
// result of the following merge. After a merge both lists start empty again.
// The input side is not ready while a merge is in progress. Command 3 is
// accepted and ignored.
module sparse_polynomial_add_top #(
   parameter int TERM_DEPTH = spa_pkg::TERM_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [15:0] term_coef (signed), [25:16] term_exponent, [31:26] zero
   input  logic [spa_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [16:0] sum_coef (signed), [26:17] sum_exponent, [31:27] zero
   output logic [spa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] terms_dropped
   output logic [0:0]                     rsp_tuser,
   // last_term
   output logic                           rsp_tlast
);
   import spa_pkg::*;

   localparam int ADDR_W = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TERM_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_EVAL   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] first_cnt_ff, first_cnt_in;
   logic [CNT_W-1:0] second_cnt_ff, second_cnt_in;
   logic [CNT_W-1:0] a_idx_ff, a_idx_in;
   logic [CNT_W-1:0] b_idx_ff, b_idx_in;
   logic             overflow_ff, overflow_in;

   // Held-back result term.
   logic                    pend_valid_ff, pend_valid_in;
   logic signed [SUM_W-1:0] pend_coef_ff, pend_coef_in;
   logic [EXP_W-1:0]        pend_exp_ff, pend_exp_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_coef_ff, rsp_coef_in;
   logic [EXP_W-1:0]        rsp_exp_ff, rsp_exp_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_drop_ff, rsp_drop_in;

   cmd_type                 req_cmd;
   logic [ENTRY_W-1:0]      req_entry;
   logic                    req_fire;
   logic                    out_free;
   logic                    first_full;
   logic                    second_full;
   logic                    first_wr;
   logic                    second_wr;
   logic                    a_live;
   logic                    b_live;
   logic [ENTRY_W-1:0]      a_entry;
   logic [ENTRY_W-1:0]      b_entry;
   pick_type                pick;

   assign req_cmd     = cmd_type'(req_tuser);
   assign req_entry   = {req_tdata[COEF_W-1:0], req_tdata[COEF_W+EXP_W-1:COEF_W]};
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign first_full  = (first_cnt_ff == CNT_W'(TERM_DEPTH));
   assign second_full = (second_cnt_ff == CNT_W'(TERM_DEPTH));
   assign first_wr    = req_fire && (req_cmd == CMD_LOAD_FIRST) && !first_full;
   assign second_wr   = req_fire && (req_cmd == CMD_LOAD_SECOND) && !second_full;
   assign a_live      = (a_idx_ff < first_cnt_ff);
   assign b_live      = (b_idx_ff < second_cnt_ff);

   spa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TERM_DEPTH)
   ) u_first_ram (
      .clock   (clock),
      .wr_en   (first_wr),
      .wr_addr (first_cnt_ff[ADDR_W-1:0]),
      .wr_data (req_entry),
      .rd_addr (a_idx_ff[ADDR_W-1:0]),
      .rd_data (a_entry)
   );

   spa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TERM_DEPTH)
   ) u_second_ram (
      .clock   (clock),
      .wr_en   (second_wr),
      .wr_addr (second_cnt_ff[ADDR_W-1:0]),
      .wr_data (req_entry),
      .rd_addr (b_idx_ff[ADDR_W-1:0]),
      .rd_data (b_entry)
   );

   spa_term_alu u_alu (
      .a_entry (a_entry),
      .b_entry (b_entry),
      .a_live  (a_live),
      .b_live  (b_live),
      .pick    (pick)
   );

   always_comb begin
      state_in      = state_ff;
      first_cnt_in  = first_cnt_ff;
      second_cnt_in = second_cnt_ff;
      a_idx_in      = a_idx_ff;
      b_idx_in      = b_idx_ff;
      overflow_in   = overflow_ff;
      pend_valid_in = pend_valid_ff;
      pend_coef_in  = pend_coef_ff;
      pend_exp_in   = pend_exp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_coef_in   = rsp_coef_ff;
      rsp_exp_in    = rsp_exp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_drop_in   = rsp_drop_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_cmd)
                  CMD_LOAD_FIRST: begin
                     if (first_full) begin
                        overflow_in = 1'b1;
                     end else begin
                        first_cnt_in = first_cnt_ff + CNT_W'(1);
                     end
                  end
                  CMD_LOAD_SECOND: begin
                     if (second_full) begin
                        overflow_in = 1'b1;
                     end else begin
                        second_cnt_in = second_cnt_ff + CNT_W'(1);
                     end
                  end
                  CMD_MERGE: begin
                     a_idx_in      = '0;
                     b_idx_in      = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_READ: begin
            // The RAMs capture the head addresses this cycle.
            if (a_live || b_live) begin
               state_in = ST_EVAL;
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_EVAL: begin
            // A new term displaces the held one, which then needs the result register.
            if (!(pick.has_term && pend_valid_ff && !out_free)) begin
               if (pick.has_term) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_coef_in  = pend_coef_ff;
                     rsp_exp_in   = pend_exp_ff;
                     rsp_last_in  = 1'b0;
                     rsp_drop_in  = overflow_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_coef_in  = pick.coef;
                  pend_exp_in   = pick.expo;
               end
               if (pick.take_a) begin
                  a_idx_in = a_idx_ff + CNT_W'(1);
               end
               if (pick.take_b) begin
                  b_idx_in = b_idx_ff + CNT_W'(1);
               end
               state_in = ST_READ;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_coef_in   = pend_valid_ff ? pend_coef_ff : '0;
               rsp_exp_in    = pend_valid_ff ? pend_exp_ff : '0;
               rsp_last_in   = 1'b1;
               rsp_drop_in   = overflow_ff;
               pend_valid_in = 1'b0;
               first_cnt_in  = '0;
               second_cnt_in = '0;
               overflow_in   = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_cnt_ff  <= '0;
         second_cnt_ff <= '0;
         a_idx_ff      <= '0;
         b_idx_ff      <= '0;
         overflow_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_cnt_ff  <= first_cnt_in;
         second_cnt_ff <= second_cnt_in;
         a_idx_ff      <= a_idx_in;
         b_idx_ff      <= b_idx_in;
         overflow_ff   <= overflow_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_coef_ff <= pend_coef_in;
      pend_exp_ff  <= pend_exp_in;
      rsp_coef_ff  <= rsp_coef_in;
      rsp_exp_ff   <= rsp_exp_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {(RSP_DATA_W - SUM_W - EXP_W)'(0), rsp_exp_ff, rsp_coef_ff};
   assign rsp_tuser[0] = rsp_drop_ff;
   assign rsp_tlast    = rsp_last_ff;

   // Counts never exceed the store depth.
   assert property (@(posedge clock) disable iff (reset)
      (first_cnt_ff <= CNT_W'(TERM_DEPTH)) && (second_cnt_ff <= CNT_W'(TERM_DEPTH)))
      else $error("term count beyond store depth");

   // Evaluation only happens while at least one list still has terms.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> (a_live || b_live))
      else $error("merge step with both lists exhausted");

   // Finishing a merge empties both lists and the drop flag.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=>
         (first_cnt_ff == '0 && second_cnt_ff == '0 && !overflow_ff && rsp_tlast))
      else $error("merge end did not clear the lists");

   // No term is left held back once the block is idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held term left behind after merge");

endmodule
